/* src/f32rem_pkg.sv */
// Package for the binary32 remainder unit: types, constants and the controller command struct.
`default_nettype none
package f32rem_pkg;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] EXP_ALL = 31'h7F80_0000;
  localparam int MANT_W = 24;
  localparam int EXP_W = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOOP,
    ST_POST,
    ST_PACK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic norm;
    logic step;
    logic post;
    logic pack;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic norm_done;
    logic loop_done;
    logic post_done;
  } stat_t;
endpackage
`default_nettype wire

/* src/f32rem_datapath.sv */
// Datapath of the binary32 remainder unit: unpack, shift-subtract loop, normalise and pack.
`default_nettype none
module f32rem_datapath
  import f32rem_pkg::*;
(
  input  wire logic        clk,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] in_dividend,
  input  wire logic [31:0] in_divisor,
  output stat_t            stat,
  output logic [31:0]      result
);
  logic [31:0] x_r, x_nxt;
  logic [MANT_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic signed [EXP_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [MANT_W:0] r_r, r_nxt;
  logic [31:0] res_r, res_nxt;
  logic special_r, special_nxt;
  logic [30:0] ax, ay;
  logic [MANT_W:0] r_shl;
  logic signed [EXP_W-1:0] shamt;
  logic [4:0] sh5;

  assign ax = in_dividend[30:0];
  assign ay = in_divisor[30:0];
  assign r_shl = {r_r[MANT_W-1:0], 1'b0};
  assign shamt = EXP_W'(1) - ey_r;
  assign sh5 = (shamt > EXP_W'(31)) ? 5'd31 : shamt[4:0];

  // Status for the controller.
  assign stat.special = special_r;
  assign stat.norm_done = mx_r[MANT_W-1] && my_r[MANT_W-1];
  assign stat.loop_done = (ex_r <= ey_r);
  assign stat.post_done = (r_r == '0) || r_r[MANT_W-1];
  assign result = res_r;

  // Register updates driven by the controller commands.
  always_comb begin
    x_nxt = x_r; mx_nxt = mx_r; my_nxt = my_r; ex_nxt = ex_r; ey_nxt = ey_r;
    r_nxt = r_r; res_nxt = res_r; special_nxt = special_r;
    if (cmd.load) begin
      x_nxt = in_dividend;
      special_nxt = 1'b1;
      if (ax < ay) begin
        res_nxt = (ay > EXP_ALL) ? QNAN_BITS : in_dividend;
      end else if (ay == '0 || ax >= EXP_ALL) begin
        res_nxt = QNAN_BITS;
      end else begin
        special_nxt = 1'b0;
      end
      mx_nxt = {(ax[30:23] != '0), ax[22:0]};
      my_nxt = {(ay[30:23] != '0), ay[22:0]};
      ex_nxt = (ax[30:23] == '0) ? EXP_W'(1) : EXP_W'({2'b00, ax[30:23]});
      ey_nxt = (ay[30:23] == '0) ? EXP_W'(1) : EXP_W'({2'b00, ay[30:23]});
    end else if (cmd.norm) begin
      // One normalising shift per cycle for each subnormal operand.
      if (!mx_r[MANT_W-1]) begin
        mx_nxt = {mx_r[MANT_W-2:0], 1'b0};
        ex_nxt = ex_r - EXP_W'(1);
      end
      if (!my_r[MANT_W-1]) begin
        my_nxt = {my_r[MANT_W-2:0], 1'b0};
        ey_nxt = ey_r - EXP_W'(1);
      end
      if (mx_r[MANT_W-1] && my_r[MANT_W-1]) begin
        r_nxt = ({1'b0, mx_r} >= {1'b0, my_r}) ? {1'b0, mx_r - my_r} : {1'b0, mx_r};
      end
    end else if (cmd.step) begin
      // One remainder bit per exponent step.
      r_nxt = (r_shl >= {1'b0, my_r}) ? r_shl - {1'b0, my_r} : r_shl;
      ex_nxt = ex_r - EXP_W'(1);
    end else if (cmd.post) begin
      r_nxt = r_shl;
      ey_nxt = ey_r - EXP_W'(1);
    end else if (cmd.pack) begin
      if (r_r == '0) begin
        res_nxt = {x_r[31], 31'd0};
      end else if (ey_r >= EXP_W'(1)) begin
        res_nxt = {x_r[31], ey_r[7:0], r_r[22:0]};
      end else begin
        res_nxt = {x_r[31], 31'(r_r[MANT_W-1:0] >> sh5)};
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    x_r <= x_nxt; mx_r <= mx_nxt; my_r <= my_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    r_r <= r_nxt; res_r <= res_nxt; special_r <= special_nxt;
  end
endmodule
`default_nettype wire

/* src/f32rem_ctrl.sv */
// Controller state machine of the binary32 remainder unit.
`default_nettype none
module f32rem_ctrl
  import f32rem_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);
  state_t state_r, state_nxt;
  logic done_r, done_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign done = done_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.special) begin
          done_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.norm = 1'b1;
          if (stat.norm_done) state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.loop_done) state_nxt = ST_POST;
        else cmd.step = 1'b1;
      end
      ST_POST: begin
        if (stat.post_done) state_nxt = ST_PACK;
        else cmd.post = 1'b1;
      end
      ST_PACK: begin
        cmd.pack = 1'b1;
        done_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* src/float32_remainder_fmod_unit.sv */
// Top level of the binary32 remainder (fmod) unit.
//
// Usage: drive in_dividend and in_divisor with binary32 bit patterns and
// pulse start while busy is low; the request is taken at that edge.
// busy stays high until the result has been produced. The result appears
// on out_remainder for exactly one cycle, marked by out_valid, and the
// receiver cannot hold it off.
// Special cases (NaN, infinite dividend, zero divisor, |x| < |y|) are
// settled at load and skip the loop. Otherwise the unit normalises
// subnormal operands, runs the shift-subtract loop over ex - ey, one
// remainder bit per cycle, and then normalises and packs the remainder.
// One request is in flight at a time; a new one may be taken in the
// cycle in which out_valid is high. Reset (rst_n low, synchronous)
// returns the controller to idle and drops any request in progress.
`default_nettype none
module float32_remainder_fmod_unit
  import f32rem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_dividend,
  input  wire logic [31:0] in_divisor,
  output logic             out_valid,
  output logic [31:0]      out_remainder
);
  cmd_t cmd;
  stat_t stat;

  f32rem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .done(out_valid)
  );

  f32rem_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_dividend(in_dividend), .in_divisor(in_divisor),
    .stat(stat), .result(out_remainder)
  );
endmodule
`default_nettype wire

/* src/f32rem_checker.sv */
// Port-level assertions for the binary32 remainder unit, bound to the top level.
`default_nettype none
module f32rem_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_remainder
);
  // An accepted request makes the unit busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after request");
  // A result never appears while a request is still in progress.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  // A result follows only from a finished request.
  a_valid_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");
  // The strobe lasts one cycle.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  // A delivered remainder is always fully defined.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_remainder)) else $error("undefined remainder");
endmodule

bind float32_remainder_fmod_unit f32rem_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_remainder(out_remainder)
);
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the binary32 remainder (fmod) unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import f32rem_pkg::*;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
  localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [31:0] in_dividend;
  logic [31:0] in_divisor;
  logic out_valid;
  logic [31:0] out_remainder;

  logic [31:0] remainder_queue[$];
  logic [31:0] dividend_log[$];
  logic [31:0] divisor_log[$];
  int error_count;
  int idle_cycles;
  bit idling_enabled;

  float32_remainder_fmod_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_dividend(in_dividend),
    .in_divisor(in_divisor),
    .out_valid(out_valid),
    .out_remainder(out_remainder)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Split a finite nonzero magnitude into a 24-bit mantissa and an exponent.
  function automatic void split_magnitude(input logic [31:0] mag, output logic [31:0] mant,
                                          output int expo);
    mant = mag & FRAC_MASK;
    if (mag[30:23] == 8'd0) begin
      expo = 1;
      while ((mant & HIDDEN_BIT) == 0) begin
        mant = mant << 1;
        expo--;
      end
    end else begin
      expo = int'(mag[30:23]);
      mant = mant | HIDDEN_BIT;
    end
  endfunction

  // Exact binary32 remainder with the sign of the dividend.
  function automatic logic [31:0] fmod_bits(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] sx, ax, ay, mx, my, r;
    int ex, ey, shift;
    sx = x & SIGN_BIT;
    ax = x & ~SIGN_BIT;
    ay = y & ~SIGN_BIT;
    if (ax < ay) begin
      if (ay > POS_INF) return QNAN_BITS;
      return x;
    end
    if (ay == 0 || ax >= POS_INF) return QNAN_BITS;
    split_magnitude(ax, mx, ex);
    split_magnitude(ay, my, ey);
    r = mx;
    if (r >= my) r = r - my;
    for (int d = ex - ey; d > 0; d--) begin
      r = r << 1;
      if (r >= my) r = r - my;
    end
    if (r == 0) return sx;
    while ((r & HIDDEN_BIT) == 0) begin
      r = r << 1;
      ey--;
    end
    if (ey >= 1) return sx | (32'(ey) << 23) | (r & FRAC_MASK);
    shift = 1 - ey;
    if (shift > 31) shift = 31;
    return sx | (r >> shift);
  endfunction

  // Random idle burst on the request side.
  task automatic maybe_pause();
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Send one request and record its expected remainder; start stays high
  // so that a following request can be taken without a gap.
  task automatic send_request(input logic [31:0] x, input logic [31:0] y);
    maybe_pause();
    start <= 1'b1;
    in_dividend <= x;
    in_divisor <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    remainder_queue.push_back(fmod_bits(x, y));
    dividend_log.push_back(x);
    divisor_log.push_back(y);
  endtask

  // Wait until every expected remainder has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    while (remainder_queue.size() != 0) @(posedge clk);
  endtask

  // Random operand with a bounded exponent difference to the other one.
  function automatic logic [31:0] near_operand(input logic [31:0] other, input int spread);
    logic [31:0] v;
    int e;
    e = int'(other[30:23]) + $urandom_range(0, 2 * spread) - spread;
    if (e < 0) e = 0;
    if (e > 254) e = 254;
    v = $urandom;
    v[30:23] = 8'(e);
    return v;
  endfunction

  // Extremes of the fields and each special case.
  task automatic test_directed();
    send_request(32'h40A0_0000, 32'h4040_0000);   // 5 fmod 3
    send_request(32'hC0A0_0000, 32'h4040_0000);   // negative dividend
    send_request(32'h40C0_0000, 32'hC040_0000);   // zero remainder, positive
    send_request(32'hC0C0_0000, 32'h4040_0000);   // zero remainder keeps the sign
    send_request(32'h7FC0_0001, 32'h3F80_0000);   // NaN dividend
    send_request(32'h3F80_0000, 32'hFFFF_FFFF);   // NaN divisor
    send_request(32'h7F80_0000, 32'h3F80_0000);   // infinite dividend
    send_request(32'h3F80_0000, 32'h0000_0000);   // zero divisor
    send_request(32'h3F80_0000, 32'h8000_0000);   // negative zero divisor
    send_request(32'h3F80_0000, 32'h7F80_0000);   // finite over infinity
    send_request(32'h8000_0000, 32'h3F80_0000);   // signed zero dividend
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h3F00_0000, 32'h3F80_0000);   // dividend smaller
    send_request(32'h7F7F_FFFF, 32'h0000_0001);   // longest loop
    send_request(32'h7F7F_FFFF, 32'h007F_FFFF);
    send_request(32'h0000_0007, 32'h0000_0003);   // subnormal both
    send_request(32'h3F80_0001, 32'h3F80_0000);   // subnormal-ish result
    send_request(32'h0080_0001, 32'h0080_0000);   // subnormal result
    send_request(32'hFF7F_FFFF, 32'hFF7F_FFFE);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h7F80_0000, 32'h7F80_0000);
    send_request(32'h7F80_0000, 32'h7FC0_0000);
  endtask

  // Random operands, mostly with nearby exponents to keep runs short.
  task automatic test_random(input int count);
    logic [31:0] x, y;
    for (int i = 0; i < count; i++) begin
      y = $urandom;
      case ($urandom_range(0, 9))
        0: x = $urandom;
        1: begin
          y[30:23] = 8'd0;
          x = near_operand(y, 3);
          x[30:23] = 8'($urandom_range(0, 2));
        end
        2: begin
          x = $urandom;
          y[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          if (y[30:23] == 8'hFF) y[30:23] = 8'hFE;
          x = near_operand(y, 30);
        end
      endcase
      send_request(x, y);
    end
  endtask

  // Hold requests back until the unit has delivered everything.
  task automatic test_drain_pause();
    wait_for_results();
    send_request(32'h4120_0000, 32'h4040_0000);
    wait_for_results();
    send_request(32'h4B00_0001, 32'h3DCC_CCCD);
  endtask

  // Compare each remainder with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (remainder_queue.size() == 0) begin
        $display("%0t: unexpected remainder %h", $time, out_remainder);
        error_count++;
      end else begin
        if (out_remainder !== remainder_queue[0]) begin
          $display("%0t: x=%h y=%h expected %h actual %h", $time, dividend_log[0],
                   divisor_log[0], remainder_queue[0], out_remainder);
          error_count++;
        end
        void'(remainder_queue.pop_front());
        void'(dividend_log.pop_front());
        void'(divisor_log.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("float32_remainder_fmod_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    idling_enabled = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_dividend = '0;
    in_divisor = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_drain_pause();
    test_random(200);
    idling_enabled = 1'b0;
    test_random(80);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && remainder_queue.size() == 0) begin
      $display("float32_remainder_fmod_unit regression: pass");
    end else begin
      $display("float32_remainder_fmod_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
